// ===== sv/psfr_pkg.sv =====
// Package: shared constants, types and command codes for the swing-foot reference block
package psfr_pkg;

  localparam int TableDepthDefault = 32;
  localparam int PhaseW            = 5;
  localparam int PosW              = 32;
  localparam int TimeW             = 32;
  localparam int HeightW           = 20;
  localparam int DurW              = 24;
  localparam int PeriodW           = 25;
  localparam int RateW             = 17;
  localparam int CfgIdxW           = 3;
  localparam int CfgDataW          = 32;

  localparam logic CMD_QUERY = 1'b0;
  localparam logic CMD_LOAD  = 1'b1;

  localparam logic [CfgIdxW-1:0] REG_SWING_HEIGHT = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_START_TIME   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SWING_DUR    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_STANCE_DUR   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_PHASES       = 3'd4;

  localparam logic [RateW-1:0] RATE_ONE  = 17'h10000;
  localparam logic [RateW-1:0] RATE_HALF = 17'h08000;

  // Controller -> datapath commands
  typedef struct packed {
    logic capture;    // latch query phase and time
    logic rem_start;  // begin dt mod period
    logic rem_step;   // one remainder iteration
    logic rate_start; // begin (rem<<16)/swing
    logic rate_step;  // one quotient iteration
    logic rd_issue;   // read table at this phase
    logic rd_next;    // read table at next phase
    logic lat_a;      // latch phase entry
    logic lat_b;      // latch next entry
    logic mul_step;   // one blend / bump stage
    logic out_load;   // load result register
    logic out_zero;   // result is inactive
    logic out_err;    // result is index error
  } psfr_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic after_start;
    logic range_err;
    logic contact;
  } psfr_sts_t;

endpackage

// ===== sv/psfr_if.sv =====
// Interfaces: valid/ready channels for items, results and configuration
interface psfr_in_if;
  import psfr_pkg::*;
  logic             valid;
  logic             ready;
  logic             command;
  logic [PhaseW-1:0] phase_index;
  logic signed [PosW-1:0] load_x;
  logic signed [PosW-1:0] load_y;
  logic signed [PosW-1:0] load_z;
  logic             load_in_contact;
  logic [TimeW-1:0] query_time;
  modport source (output valid, command, phase_index, load_x, load_y, load_z,
                  load_in_contact, query_time, input ready);
  modport sink   (input valid, command, phase_index, load_x, load_y, load_z,
                  load_in_contact, query_time, output ready);
endinterface

interface psfr_out_if;
  import psfr_pkg::*;
  logic valid;
  logic ready;
  logic swing_active;
  logic signed [PosW-1:0] ref_x;
  logic signed [PosW-1:0] ref_y;
  logic signed [PosW-1:0] ref_z;
  logic index_error;
  modport source (output valid, swing_active, ref_x, ref_y, ref_z, index_error,
                  input ready);
  modport sink   (input valid, swing_active, ref_x, ref_y, ref_z, index_error,
                  output ready);
endinterface

interface psfr_cfg_if;
  import psfr_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/psfr_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data
module psfr_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/psfr_datapath.sv =====
// Datapath: config registers, table, serial divider, blend multipliers, result register
module psfr_datapath #(
  parameter int TableDepth = psfr_pkg::TableDepthDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [psfr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [psfr_pkg::CfgDataW-1:0] cfg_data,
  input  logic                          load_we,
  input  logic [psfr_pkg::PhaseW-1:0]   in_phase,
  input  logic [psfr_pkg::PosW-1:0]     in_x,
  input  logic [psfr_pkg::PosW-1:0]     in_y,
  input  logic [psfr_pkg::PosW-1:0]     in_z,
  input  logic                          in_contact,
  input  logic [psfr_pkg::TimeW-1:0]    in_time,
  input  psfr_pkg::psfr_cmd_t           cmd,
  output psfr_pkg::psfr_sts_t           sts,
  output logic                          res_active,
  output logic [psfr_pkg::PosW-1:0]     res_x,
  output logic [psfr_pkg::PosW-1:0]     res_y,
  output logic [psfr_pkg::PosW-1:0]     res_z,
  output logic                          res_err
);
  import psfr_pkg::*;

  localparam int AddrW = $clog2(TableDepth);
  localparam int EntW  = 3*PosW + 1;
  localparam int DivW  = 49;   // rem << 16 fits 41 bits; width of shift register

  // configuration registers
  logic [HeightW-1:0] height_r;
  logic [TimeW-1:0]   start_r;
  logic [DurW-1:0]    swing_r, stance_r;
  logic [PhaseW-1:0]  phases_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= '0;
      start_r  <= '0;
      swing_r  <= DurW'(65536);
      stance_r <= DurW'(65536);
      phases_r <= PhaseW'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SWING_HEIGHT: height_r <= cfg_data[HeightW-1:0];
        REG_START_TIME:   start_r  <= cfg_data;
        REG_SWING_DUR:    swing_r  <= cfg_data[DurW-1:0];
        REG_STANCE_DUR:   stance_r <= cfg_data[DurW-1:0];
        REG_PHASES:       phases_r <= cfg_data[PhaseW-1:0];
        default: ;
      endcase
    end
  end

  // query phase and range checks
  logic [PhaseW-1:0] phase_r;
  logic [TimeW-1:0]  time_r;
  logic [PhaseW:0]   next_full;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      phase_r <= in_phase;
      time_r  <= in_time;
    end
  end
  assign next_full = {1'b0, phase_r} + {1'b0, phases_r};

  // table memory: x, y, z, contact packed in one word
  logic            ram_we;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [EntW-1:0]  ram_wdata, ram_rdata;
  logic             load_ok;

  assign load_ok   = (32'(in_phase) < 32'(TableDepth));
  assign ram_we    = load_we && load_ok;
  assign ram_waddr = AddrW'(in_phase);
  assign ram_wdata = {in_x, in_y, in_z, in_contact};
  assign ram_raddr = cmd.rd_next ? AddrW'(next_full) : AddrW'(phase_r);

  psfr_ram #(.Width(EntW), .Depth(TableDepth)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic [EntW-1:0] ent_a_r, ent_b_r;
  always_ff @(posedge clk) begin
    if (cmd.lat_a) ent_a_r <= ram_rdata;
    if (cmd.lat_b) ent_b_r <= ram_rdata;
  end

  assign sts.after_start = (time_r > start_r);
  assign sts.range_err   = (32'(phase_r) >= 32'(TableDepth)) ||
                           (32'(next_full) >= 32'(TableDepth));
  assign sts.contact     = ent_a_r[0];

  // shared restoring divider: remainder pass then quotient pass
  logic [DivW-1:0]   num_r;
  logic [PeriodW-1:0] den_r;
  logic [PeriodW:0]  part_r;
  logic [PeriodW:0]  part_sh, part_sub;
  logic [PeriodW-1:0] period;
  logic [RateW-1:0]  rate_r;
  logic [TimeW-1:0]  dt;

  assign period   = {1'b0, swing_r} + {1'b0, stance_r};
  assign dt       = time_r - start_r;
  assign part_sh  = {part_r[PeriodW-1:0], num_r[DivW-1]};
  assign part_sub = part_sh - {1'b0, den_r};

  // quotient saturates at one; rate_r catches the low bits plus an overflow flag
  logic over_r;
  always_ff @(posedge clk) begin
    if (cmd.rem_start) begin
      num_r  <= {dt, {(DivW-TimeW){1'b0}}};
      den_r  <= period;
      part_r <= '0;
    end else if (cmd.rate_start) begin
      // remainder sits in part_r; numerator is rem << 16
      num_r  <= {part_r[PeriodW-1:0], 16'd0, {(DivW-PeriodW-16){1'b0}}};
      den_r  <= {1'b0, swing_r};
      part_r <= '0;
      rate_r <= '0;
      over_r <= 1'b0;
    end else if (cmd.rem_step || cmd.rate_step) begin
      num_r <= {num_r[DivW-2:0], 1'b0};
      if (!part_sub[PeriodW] && den_r != '0) begin
        part_r <= part_sub;
      end else begin
        part_r <= part_sh;
      end
      if (cmd.rate_step) begin
        rate_r <= {rate_r[RateW-2:0], (!part_sub[PeriodW] && den_r != '0)};
        over_r <= over_r | rate_r[RateW-1];
      end
    end
  end

  logic [RateW-1:0] rate_sat;
  assign rate_sat = (swing_r == '0 || over_r || rate_r > RATE_ONE) ? RATE_ONE : rate_r;

  // blend: one coordinate product per step, registered
  logic [2:0] mstep_r;
  logic signed [PosW+RateW:0] pa_r, pb_r;
  logic signed [PosW+RateW+1:0] sum;
  logic [PosW-1:0] bx_r, by_r, bz_r;
  logic [RateW-1:0] bump_w;
  logic [HeightW+RateW-1:0] bump_r;
  logic signed [PosW-1:0] sel_a, sel_b;
  logic signed [RateW:0] ra, rb;

  always_comb begin
    case (mstep_r)
      3'd0, 3'd1: begin sel_a = ent_a_r[EntW-1 -: PosW]; sel_b = ent_b_r[EntW-1 -: PosW]; end
      3'd2, 3'd3: begin sel_a = ent_a_r[2*PosW -: PosW]; sel_b = ent_b_r[2*PosW -: PosW]; end
      default:    begin sel_a = ent_a_r[PosW -: PosW];   sel_b = ent_b_r[PosW -: PosW];   end
    endcase
  end
  assign ra     = $signed({1'b0, RATE_ONE - rate_sat});
  assign rb     = $signed({1'b0, rate_sat});
  assign sum    = pa_r + pb_r;
  assign bump_w = (rate_sat < RATE_HALF) ? rate_sat : (RATE_ONE - rate_sat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mstep_r <= '0;
    end else if (cmd.rate_start) begin
      mstep_r <= '0;
    end else if (cmd.mul_step) begin
      mstep_r <= mstep_r + 3'd1;
    end
  end

  // even steps multiply, odd steps add and store
  always_ff @(posedge clk) begin
    if (cmd.mul_step) begin
      if (!mstep_r[0]) begin
        pa_r <= (PosW+RateW+1)'(sel_a * ra);
        pb_r <= (PosW+RateW+1)'(sel_b * rb);
        if (mstep_r == 3'd0) bump_r <= bump_w * height_r;
      end else begin
        case (mstep_r)
          3'd1:    bx_r <= sum[PosW+15:16];
          3'd3:    by_r <= sum[PosW+15:16];
          default: bz_r <= sum[PosW+15:16];
        endcase
      end
    end
  end

  // z with bump, saturated at the top
  logic signed [PosW+1:0] zsum;
  assign zsum = $signed({{2{bz_r[PosW-1]}}, bz_r}) +
                $signed({2'b00, bump_r[HeightW+RateW-1:15]});

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_zero || cmd.out_err) begin
        res_active <= 1'b0;
        res_x <= '0; res_y <= '0; res_z <= '0;
        res_err <= cmd.out_err;
      end else begin
        res_active <= 1'b1;
        res_x <= bx_r;
        res_y <= by_r;
        res_z <= (zsum > $signed({2'b00, 32'h7FFFFFFF})) ? 32'h7FFFFFFF : zsum[PosW-1:0];
        res_err <= 1'b0;
      end
    end
  end
endmodule

// ===== sv/psfr_ctrl.sv =====
// Controller: sequences load, range check, table reads, two divides and the blend
module psfr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_command,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                load_we,
  output psfr_pkg::psfr_cmd_t cmd,
  input  psfr_pkg::psfr_sts_t sts
);
  import psfr_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_RDA   = 4'd2;
  localparam logic [3:0] S_RDB   = 4'd3;
  localparam logic [3:0] S_LATB  = 4'd4;
  localparam logic [3:0] S_REM   = 4'd5;
  localparam logic [3:0] S_RATE  = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  localparam logic [5:0] REM_STEPS  = 6'd32;
  localparam logic [5:0] RATE_STEPS = 6'd41;
  localparam logic [5:0] MUL_STEPS  = 6'd6;

  logic [3:0] state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       take;

  assign in_ready  = (state_r == S_IDLE) && !ovalid_r;
  assign out_valid = ovalid_r;
  assign take      = in_valid && in_ready;
  assign load_we   = take && (in_command == CMD_LOAD);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    ovalid_nxt = ovalid_r && !out_ready;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (take && in_command == CMD_QUERY) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.after_start) begin
          cmd.out_load = 1'b1; cmd.out_zero = 1'b1; state_nxt = S_DONE;
        end else if (sts.range_err) begin
          cmd.out_load = 1'b1; cmd.out_err = 1'b1; state_nxt = S_DONE;
        end else begin
          cmd.rd_issue = 1'b1; state_nxt = S_RDA;
        end
      end
      S_RDA: begin
        cmd.rd_next = 1'b1; cmd.lat_a = 1'b1; state_nxt = S_RDB;
      end
      S_RDB: begin
        cmd.lat_b = 1'b1; state_nxt = S_LATB;
      end
      S_LATB: begin
        if (sts.contact) begin
          cmd.out_load = 1'b1; cmd.out_zero = 1'b1; state_nxt = S_DONE;
        end else begin
          cmd.rem_start = 1'b1; cnt_nxt = '0; state_nxt = S_REM;
        end
      end
      S_REM: begin
        if (cnt_r == REM_STEPS) begin
          cmd.rate_start = 1'b1; cnt_nxt = '0; state_nxt = S_RATE;
        end else begin
          cmd.rem_step = 1'b1; cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_RATE: begin
        if (cnt_r == RATE_STEPS) begin
          cnt_nxt = '0; state_nxt = S_MUL;
        end else begin
          cmd.rate_step = 1'b1; cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_MUL: begin
        if (cnt_r == MUL_STEPS) begin
          cmd.out_load = 1'b1; state_nxt = S_DONE;
        end else begin
          cmd.mul_step = 1'b1; cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_DONE: begin
        ovalid_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end
endmodule

// ===== sv/periodic_swing_foot_reference_core.sv =====
// Top level: swing-foot reference generator with table, serial divider and blend
//  channel | dir | payload
//  in_     | in  | command, phase_index, load_x/y/z, load_in_contact, query_time
//  out_    | out | swing_active, ref_x/y/z, index_error
//  cfg_    | in  | index (0..4), data
// A load is written to the table as it is accepted. An early-out query takes its
// result from the check state, or from the latch state for an entry in contact.
// A full query runs on through the shared restoring divider (32 remainder and 41
// steps) and six blend steps on one multiplier pair. One item is in flight
// at a time. Synchronous active-low reset; the table holds no reset value.
// A result waits in the output register until taken; no new item enters meanwhile.
module periodic_swing_foot_reference_core #(
  parameter int TableDepth = psfr_pkg::TableDepthDefault
) (
  input logic clk,
  input logic rst_n,
  psfr_in_if.sink    in_ch,
  psfr_out_if.source out_ch,
  psfr_cfg_if.sink   cfg_ch
);
  import psfr_pkg::*;

  psfr_cmd_t cmd;
  psfr_sts_t sts;
  logic      load_we;

  assign cfg_ch.ready = 1'b1;

  psfr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .load_we    (load_we),
    .cmd        (cmd),
    .sts        (sts)
  );

  psfr_datapath #(.TableDepth(TableDepth)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_ch.valid),
    .cfg_index  (cfg_ch.index),
    .cfg_data   (cfg_ch.data),
    .load_we    (load_we),
    .in_phase   (in_ch.phase_index),
    .in_x       (in_ch.load_x),
    .in_y       (in_ch.load_y),
    .in_z       (in_ch.load_z),
    .in_contact (in_ch.load_in_contact),
    .in_time    (in_ch.query_time),
    .cmd        (cmd),
    .sts        (sts),
    .res_active (out_ch.swing_active),
    .res_x      (out_ch.ref_x),
    .res_y      (out_ch.ref_y),
    .res_z      (out_ch.ref_z),
    .res_err    (out_ch.index_error)
  );
endmodule

// ===== dv/periodic_swing_foot_reference_core_tb.sv =====
// Testbench: directed table and random transactions checked against a swing-reference predictor
`timescale 1ns / 100ps

module periodic_swing_foot_reference_core_tb;
  import psfr_pkg::*;

  localparam int Depth = TableDepthDefault;

  typedef struct packed {
    logic        cmd;
    logic [4:0]  phase;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        contact;
    logic [31:0] t;
  } item_t;

  typedef struct packed {
    logic        active;
    logic [31:0] rx;
    logic [31:0] ry;
    logic [31:0] rz;
    logic        err;
  } swing_ref_t;

  // Directed row: item plus optional typed-in expected result
  typedef struct packed {
    item_t      it;
    logic       has_exp;
    swing_ref_t exp;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  psfr_in_if  in_ch();
  psfr_out_if out_ch();
  psfr_cfg_if cfg_ch();

  periodic_swing_foot_reference_core u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state
  logic [19:0] m_height;
  logic [31:0] m_start;
  logic [23:0] m_swing;
  logic [23:0] m_stance;
  logic [4:0]  m_phases;
  logic [31:0] tbl_x [Depth];
  logic [31:0] tbl_y [Depth];
  logic [31:0] tbl_z [Depth];
  logic        tbl_c [Depth];
  bit          tbl_written [Depth];

  swing_ref_t ref_queue[$];
  int errors = 0;
  bit rx_stall_en = 1'b1;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [31:0] lerp(input logic [31:0] a, input logic [31:0] b,
                                       input logic [16:0] r);
    logic signed [63:0] s;
    s = $signed({1'b0, 17'h10000 - r}) * $signed(a) + $signed({1'b0, r}) * $signed(b);
    return s[47:16];  // arithmetic shift right by 16 gives the floor
  endfunction

  function automatic swing_ref_t predict_ref(input item_t it);
    swing_ref_t res;
    logic [5:0]  nxt;
    logic [31:0] dt;
    logic [24:0] per;
    logic [31:0] rem;
    logic [63:0] q;
    logic [16:0] r;
    logic [63:0] bump;
    logic signed [63:0] zz;
    res = '0;
    if (it.t <= m_start) return res;
    nxt = it.phase + m_phases;
    if (nxt >= Depth) begin
      res.err = 1'b1;
      return res;
    end
    if (tbl_c[it.phase]) return res;
    dt = it.t - m_start;
    per = m_swing + m_stance;
    rem = (per != 0) ? dt % per : dt;
    if (m_swing == 0) r = RATE_ONE;
    else begin
      q = ({32'd0, rem} << 16) / m_swing;
      r = (q > 64'h10000) ? RATE_ONE : q[16:0];
    end
    if (r < RATE_HALF) bump = (64'(r) * m_height) >> 15;
    else bump = (64'(RATE_ONE - r) * m_height) >> 15;
    zz = 64'($signed(lerp(tbl_z[it.phase], tbl_z[nxt[4:0]], r))) + $signed(bump);
    if (zz > 64'sd2147483647) zz = 64'sd2147483647;
    res.active = 1'b1;
    res.rx = lerp(tbl_x[it.phase], tbl_x[nxt[4:0]], r);
    res.ry = lerp(tbl_y[it.phase], tbl_y[nxt[4:0]], r);
    res.rz = zz[31:0];
    return res;
  endfunction

  // Apply an accepted transaction to the predictor
  task automatic absorb_item(input item_t it, input bit has_exp, input swing_ref_t exp);
    swing_ref_t want;
    if (it.cmd == CMD_LOAD) begin
      tbl_x[it.phase] = it.x;
      tbl_y[it.phase] = it.y;
      tbl_z[it.phase] = it.z;
      tbl_c[it.phase] = it.contact;
      tbl_written[it.phase] = 1'b1;
    end else begin
      want = has_exp ? exp : predict_ref(it);
      ref_queue.insert(ref_queue.size(), want);
    end
  endtask

  task automatic send_item(input item_t it, input bit has_exp, input swing_ref_t exp);
    in_ch.valid           <= 1'b1;
    in_ch.command         <= it.cmd;
    in_ch.phase_index     <= it.phase;
    in_ch.load_x          <= it.x;
    in_ch.load_y          <= it.y;
    in_ch.load_z          <= it.z;
    in_ch.load_in_contact <= it.contact;
    in_ch.query_time      <= it.t;
    do @(posedge clk); while (!in_ch.ready);
    absorb_item(it, has_exp, exp);
    // sender bursts: occasional gap after an item
    if ($urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // valid stays high between back-to-back writes; the caller drops it
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_SWING_HEIGHT: m_height = val[19:0];
      REG_START_TIME:   m_start  = val;
      REG_SWING_DUR:    m_swing  = val[23:0];
      REG_STANCE_DUR:   m_stance = val[23:0];
      REG_PHASES:       m_phases = val[4:0];
      default: ;
    endcase
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (ref_queue.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic item_t load_item(input logic [4:0] ph, input logic [31:0] x,
                                      input logic [31:0] y, input logic [31:0] z,
                                      input logic c);
    item_t it;
    it = '0;
    it.cmd = CMD_LOAD; it.phase = ph; it.x = x; it.y = y; it.z = z; it.contact = c;
    it.t = $urandom;
    return it;
  endfunction

  function automatic item_t query_item(input logic [4:0] ph, input logic [31:0] t);
    item_t it;
    it = '0;
    it.cmd = CMD_QUERY; it.phase = ph; it.t = t;
    it.x = $urandom; it.y = $urandom; it.z = $urandom; it.contact = 1'($urandom);
    return it;
  endfunction

  // Random query that never reads an unwritten entry
  function automatic item_t rand_query();
    item_t it;
    logic [4:0] ph;
    int n;
    n = 0;
    do begin
      ph = 5'($urandom_range(0, Depth - 1));
      n++;
    end while (n < 64 && !(tbl_written[ph] &&
               (32'(ph) + m_phases >= Depth || tbl_written[ph + m_phases])));
    case ($urandom_range(0, 5))
      0: it = query_item(ph, $urandom_range(0, 1) ? m_start : $urandom);
      1: it = query_item(ph, 32'hFFFF_FFFF);
      default: it = query_item(ph, m_start + $urandom_range(1, 3 * (m_swing + m_stance)));
    endcase
    if (!(tbl_written[ph] && (32'(ph) + m_phases >= Depth || tbl_written[ph + m_phases])))
      it.t = m_start;  // early-out, table untouched
    return it;
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000);
    endcase
  endfunction

  // Receiver: stall pattern of its own, checks every result transaction
  always @(posedge clk) begin
    swing_ref_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (ref_queue.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_ch.swing_active), 32'd0);
        end else begin
          want = ref_queue.pop_front();
          if (out_ch.swing_active !== want.active)
            report_mismatch("swing_active", 32'(out_ch.swing_active), 32'(want.active));
          if (out_ch.ref_x !== want.rx) report_mismatch("ref_x", out_ch.ref_x, want.rx);
          if (out_ch.ref_y !== want.ry) report_mismatch("ref_y", out_ch.ref_y, want.ry);
          if (out_ch.ref_z !== want.rz) report_mismatch("ref_z", out_ch.ref_z, want.rz);
          if (out_ch.index_error !== want.err)
            report_mismatch("index_error", 32'(out_ch.index_error), 32'(want.err));
        end
      end
      out_ch.ready <= !rx_stall_en || ($urandom_range(0, 7) > 2);
    end
  end

  // Stimulus
  initial begin
    row_t rows[$];
    row_t rw;
    swing_ref_t none;
    item_t it;
    none = '0;
    in_ch.valid = 1'b0; in_ch.command = CMD_QUERY; in_ch.phase_index = '0;
    in_ch.load_x = '0; in_ch.load_y = '0; in_ch.load_z = '0;
    in_ch.load_in_contact = 1'b0; in_ch.query_time = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    m_height = '0; m_start = '0; m_swing = 24'd65536; m_stance = 24'd65536; m_phases = 5'd1;
    foreach (tbl_written[i]) begin
      tbl_written[i] = 1'b0;
      tbl_x[i] = '0; tbl_y[i] = '0; tbl_z[i] = '0; tbl_c[i] = 1'b0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: reset state, extremes, inactive, contact, index error
    rw = '0; rw.it = query_item(5'd0, 32'd0); rw.has_exp = 1'b1; rw.exp = none;
    rows.insert(rows.size(), rw);
    rw = '0; rw.it = query_item(5'd31, 32'h10); rw.has_exp = 1'b1;
    rw.exp = none; rw.exp.err = 1'b1;
    rows.insert(rows.size(), rw);
    rw = '0; rw.it = load_item(5'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_0000, 1'b0);
    rows.insert(rows.size(), rw);
    rw = '0; rw.it = load_item(5'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    rows.insert(rows.size(), rw);
    rw = '0; rw.it = load_item(5'd2, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 1'b1);
    rows.insert(rows.size(), rw);
    rw = '0; rw.it = load_item(5'd3, 32'h0, 32'h0, 32'h8000_0000, 1'b0);
    rows.insert(rows.size(), rw);
    rw = '0; rw.it = load_item(5'd4, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 1'b0);
    rows.insert(rows.size(), rw);
    rw = '0; rw.it = query_item(5'd2, 32'h0002_0000); rw.has_exp = 1'b1; rw.exp = none;
    rows.insert(rows.size(), rw);
    rw = '0; rw.it = query_item(5'd0, 32'h0000_8000);
    rows.insert(rows.size(), rw);
    rw = '0; rw.it = query_item(5'd0, 32'h0001_0000);
    rows.insert(rows.size(), rw);
    rw = '0; rw.it = query_item(5'd0, 32'h0001_8000);
    rows.insert(rows.size(), rw);
    rw = '0; rw.it = query_item(5'd1, 32'hFFFF_FFFF);
    rows.insert(rows.size(), rw);
    rw = '0; rw.it = query_item(5'd3, 32'h0000_0001);
    rows.insert(rows.size(), rw);
    foreach (rows[i]) send_item(rows[i].it, rows[i].has_exp, rows[i].exp);
    wait_drain();

    // Register settings: extremes, zero-length corners, random values and a run without receiver stalls
    for (int phase_set = 0; phase_set < 8; phase_set++) begin
      case (phase_set)
        0: begin
          write_reg(REG_SWING_HEIGHT, 32'hFFFFF); write_reg(REG_START_TIME, 32'd0);
          write_reg(REG_SWING_DUR, 32'd1); write_reg(REG_STANCE_DUR, 32'd1);
          write_reg(REG_PHASES, 32'd31);
        end
        1: begin
          write_reg(REG_SWING_DUR, 32'hFFFFFF); write_reg(REG_STANCE_DUR, 32'hFFFFFF);
          write_reg(REG_PHASES, 32'd1); write_reg(REG_START_TIME, 32'hFFFF_0000);
        end
        2: begin
          write_reg(REG_SWING_DUR, 32'd0); write_reg(REG_STANCE_DUR, 32'd0);
          write_reg(REG_PHASES, 32'd0); write_reg(REG_START_TIME, 32'd100);
        end
        3: begin
          write_reg(REG_SWING_DUR, 32'd0); write_reg(REG_STANCE_DUR, 32'h20000);
          write_reg(REG_SWING_HEIGHT, 32'd0);
        end
        4: begin
          write_reg(REG_START_TIME, 32'hFFFF_FFFF); write_reg(REG_PHASES, 32'd16);
          write_reg(REG_SWING_DUR, 32'h8000);
        end
        7: rx_stall_en = 1'b0;
        default: begin
          write_reg(REG_SWING_HEIGHT, $urandom_range(0, 20'hFFFFF));
          write_reg(REG_START_TIME, $urandom_range(0, 32'h0010_0000));
          write_reg(REG_SWING_DUR, $urandom_range(1, 24'h04_0000));
          write_reg(REG_STANCE_DUR, $urandom_range(1, 24'h04_0000));
          write_reg(REG_PHASES, $urandom_range(1, 8));
        end
      endcase
      cfg_ch.valid <= 1'b0;
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 3) == 0)
          it = load_item(5'($urandom_range(0, Depth - 1)), rand_pos(), rand_pos(), rand_pos(),
                         $urandom_range(0, 3) == 0);
        else it = rand_query();
        send_item(it, 1'b0, none);
      end
      wait_drain();
    end

    if (errors == 0) begin
      $display("PASS periodic_swing_foot_reference_core");
    end else begin
      $display("FAIL periodic_swing_foot_reference_core");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("FAIL periodic_swing_foot_reference_core");
    $finish;
  end

endmodule
